// File: hw/rtl/vfhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfhp_pkg
// Shared types and constants of the frame header parser.
// ----------------------------------------------------------------------------
package vfhp_pkg;

    localparam int MaxPacket = 4096;
    localparam int LenW      = 13;
    localparam int OffW      = 12;
    localparam int HdrBytes  = 12;
    localparam int FifoDepth = 8;
    localparam int FifoAw    = $clog2(FifoDepth);
    localparam int FifoCw    = $clog2(FifoDepth + 1);

    localparam logic [7:0] TypeIax = 8'd6;

    localparam logic [2:0] StOk        = 3'd0;
    localparam logic [2:0] StShortFull = 3'd1;
    localparam logic [2:0] StShortMini = 3'd2;
    localparam logic [2:0] StShortMeta = 3'd3;
    localparam logic [2:0] StUnkMeta   = 3'd4;
    localparam logic [2:0] StOverrun   = 3'd5;
    localparam logic [2:0] StStray     = 3'd6;

    localparam logic [1:0] ShellUndef = 2'd0;
    localparam logic [1:0] ShellFull  = 2'd1;
    localparam logic [1:0] ShellMini  = 2'd2;
    localparam logic [1:0] ShellMeta  = 2'd3;

    localparam logic RecSummary = 1'b0;
    localparam logic RecElement = 1'b1;

    typedef struct packed {
        logic [7:0]      data_byte;
        logic [LenW-1:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic            record_kind;
        logic [2:0]      status;
        logic [1:0]      frame_shell;
        logic [14:0]     source_call;
        logic [15:0]     dest_word;
        logic [31:0]     time_stamp;
        logic [7:0]      out_seq;
        logic [7:0]      in_seq;
        logic [7:0]      item_code;
        logic [7:0]      subclass_byte;
        logic [LenW-1:0] item_length;
        logic [OffW-1:0] item_offset;
    } t_out_item;

    // Up to two records produced by one packet byte, in delivery order.
    typedef struct packed {
        logic      first_valid;
        t_out_item first;
        logic      second_valid;
        t_out_item second;
    } t_push;

endpackage
`default_nettype wire

// File: hw/rtl/vfhp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfhp_in_if
// Valid/ready channel carrying one packet byte and the packet length.
// ----------------------------------------------------------------------------
interface vfhp_in_if import vfhp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vfhp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfhp_out_if
// Valid/ready channel carrying one descriptor or frame summary record.
// ----------------------------------------------------------------------------
interface vfhp_out_if import vfhp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vfhp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfhp_parser
// Input register, per-packet parse state and record builder.
// ----------------------------------------------------------------------------
module vfhp_parser import vfhp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output t_push         o_push
);

    localparam logic [1:0] PhHeader = 2'd0;
    localparam logic [1:0] PhType   = 2'd1;
    localparam logic [1:0] PhLen    = 2'd2;
    localparam logic [1:0] PhData   = 2'd3;

    logic            r_in_valid;
    t_in_item        r_in;
    logic [LenW-1:0] r_byte_index, n_byte_index;
    logic [7:0]      r_hdr [HdrBytes];
    logic [1:0]      r_phase, n_phase;
    logic [7:0]      r_remaining, n_remaining;
    logic [7:0]      r_elem_type, n_elem_type;
    logic [2:0]      r_err, n_err;

    logic [LenW-1:0] len_eff;
    logic [LenW-1:0] idx_p1;
    logic            last;
    logic [LenW-1:0] rem;
    logic [7:0]      b;
    logic [7:0]      h [HdrBytes];
    logic            desc_valid;
    t_out_item       desc;
    t_out_item       summ;

    // register the accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_valid;
        end
        if (i_valid) begin
            r_in <= i_item;
        end
    end

    always_comb begin
        b = r_in.data_byte;
        if (r_in.packet_length > LenW'(MaxPacket)) begin
            len_eff = LenW'(MaxPacket);
        end else if (r_in.packet_length == '0) begin
            len_eff = LenW'(1);
        end else begin
            len_eff = r_in.packet_length;
        end
        idx_p1 = r_byte_index + LenW'(1);
        last   = (idx_p1 >= len_eff);
        rem    = last ? '0 : (len_eff - idx_p1);

        // header view including the byte in hand
        for (int k = 0; k < HdrBytes; k++) begin
            h[k] = (r_byte_index == LenW'(k)) ? b : r_hdr[k];
        end

        n_byte_index = idx_p1;
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_elem_type  = r_elem_type;
        n_err        = r_err;
        desc_valid   = 1'b0;

        if (r_byte_index == LenW'(HdrBytes - 1)) begin
            if (r_hdr[0][7] && (r_hdr[10] == TypeIax)) begin
                n_phase = PhType;
            end
        end else if ((r_byte_index >= LenW'(HdrBytes)) && (r_err == StOk)) begin
            case (r_phase)
                PhType: begin
                    n_elem_type = b;
                    if (last) begin
                        n_err   = StStray;
                        n_phase = PhHeader;
                    end else begin
                        n_phase = PhLen;
                    end
                end
                PhLen: begin
                    if ({{(LenW-8){1'b0}}, b} > rem) begin
                        n_err   = StOverrun;
                        n_phase = PhHeader;
                    end else begin
                        desc_valid = 1'b1;
                        if (b == 8'd0) begin
                            n_phase = PhType;
                        end else begin
                            n_remaining = b;
                            n_phase     = PhData;
                        end
                    end
                end
                PhData: begin
                    n_remaining = r_remaining - 8'd1;
                    if (n_remaining == 8'd0) begin
                        n_phase = PhType;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (last) begin
            n_byte_index = '0;
            n_phase      = PhHeader;
            n_remaining  = '0;
            n_elem_type  = '0;
        end

        desc             = '0;
        desc.record_kind = RecElement;
        desc.frame_shell = ShellFull;
        desc.item_code   = r_elem_type;
        desc.item_length = {{(LenW-8){1'b0}}, b};
        desc.item_offset = idx_p1[OffW-1:0];

        summ = '0;
        summ.record_kind = RecSummary;
        if (h[0][7]) begin
            if (len_eff < LenW'(HdrBytes)) begin
                summ.status = StShortFull;
            end else begin
                summ.status        = n_err;
                summ.frame_shell   = ShellFull;
                summ.source_call   = {h[0][6:0], h[1]};
                summ.dest_word     = {h[2], h[3]};
                summ.time_stamp    = {h[4], h[5], h[6], h[7]};
                summ.out_seq       = h[8];
                summ.in_seq        = h[9];
                summ.item_code     = h[10];
                summ.subclass_byte = h[11];
                summ.item_length   = len_eff - LenW'(HdrBytes);
            end
        end else if ({h[0], h[1]} != 16'd0) begin
            summ.frame_shell = ShellMini;
            if (len_eff < LenW'(4)) begin
                summ.status = StShortMini;
            end else begin
                summ.source_call = {h[0][6:0], h[1]};
                summ.time_stamp  = {16'd0, h[2], h[3]};
                summ.item_length = len_eff - LenW'(4);
            end
        end else begin
            summ.frame_shell = ShellMeta;
            if (!h[2][7]) begin
                summ.status = StUnkMeta;
            end else if (len_eff <= LenW'(6)) begin
                summ.status = StShortMeta;
            end else begin
                summ.source_call = {h[2][6:0], h[3]};
                summ.time_stamp  = {16'd0, h[4], h[5]};
                summ.item_length = len_eff - LenW'(6);
            end
        end

        o_push.first_valid  = r_in_valid && (desc_valid || last);
        o_push.first        = desc_valid ? desc : summ;
        o_push.second_valid = r_in_valid && desc_valid && last;
        o_push.second       = summ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_phase      <= PhHeader;
            r_remaining  <= '0;
            r_elem_type  <= '0;
            r_err        <= StOk;
        end else if (r_in_valid) begin
            r_byte_index <= n_byte_index;
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_elem_type  <= n_elem_type;
            r_err        <= last ? StOk : n_err;
        end
    end

    // header bytes; cleared at packet end so unreached bytes read as zero
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HdrBytes; k++) begin
            if (!i_rst_n) begin
                r_hdr[k] <= '0;
            end else if (r_in_valid) begin
                if (last) begin
                    r_hdr[k] <= '0;
                end else if (r_byte_index == LenW'(k)) begin
                    r_hdr[k] <= b;
                end
            end
        end
    end

    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && last) |=> (r_byte_index == '0 && r_phase == PhHeader))
        else $error("byte index not rewound after last byte");

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PhData) |-> (r_remaining != 8'd0))
        else $error("data phase with no bytes left");

    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.second_valid |-> (o_push.first_valid &&
                                 o_push.first.record_kind == RecElement))
        else $error("second record without a descriptor ahead of it");

endmodule
`default_nettype wire

// File: hw/rtl/vfhp_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfhp_out_fifo
// Record queue with two write slots per cycle and one read port.
// ----------------------------------------------------------------------------
module vfhp_out_fifo import vfhp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_push     i_push,
    input  wire logic      i_pop,
    output t_out_item      o_head,
    output logic           o_valid,
    output logic [FifoCw-1:0] o_count
);

    t_out_item         r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wp, n_wp;
    logic [FifoAw-1:0] r_rp;
    logic [FifoCw-1:0] r_count;
    logic [1:0]        push_n;
    logic              pop_ok;

    always_comb begin
        push_n  = {1'b0, i_push.first_valid} + {1'b0, i_push.second_valid};
        pop_ok  = i_pop && (r_count != '0);
        n_wp    = r_wp + FifoAw'(push_n);
        o_valid = (r_count != '0);
        o_head  = r_mem[r_rp];
        o_count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first_valid) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.second_valid) begin
            r_mem[r_wp + FifoAw'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            if (pop_ok) begin
                r_rp <= r_rp + FifoAw'(1);
            end
            r_count <= r_count + FifoCw'(push_n) - FifoCw'(pop_ok);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + FifoCw'(push_n) - FifoCw'(pop_ok)) <= FifoCw'(FifoDepth))
        else $error("record queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FifoCw'(FifoDepth))
        else $error("record count out of range");

endmodule
`default_nettype wire

// File: hw/rtl/voip_frame_header_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voip_frame_header_parser_top
// Streaming frame header parser: one packet byte in, descriptors and summary out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while ready is high; a byte may yield up to two records.
// Path: a record passes the input register, then is written to the 8-entry record
//   queue, from whose head it is offered.
// Ready drops only when the queue could not absorb two more records from the
//   byte in flight and the next one; a stalled consumer backs up into it.
// Reset: synchronous, active low; clears the parse state, header bytes and queue.
// ----------------------------------------------------------------------------
module voip_frame_header_parser_top import vfhp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vfhp_in_if.sink    i_in,
    vfhp_out_if.source o_out
);

    t_push             push;
    logic [FifoCw-1:0] count;
    logic [1:0]        push_n;
    logic              accept;

    // admit a byte only if the pending byte's records and a full pair after it fit
    always_comb begin
        push_n     = {1'b0, push.first_valid} + {1'b0, push.second_valid};
        i_in.ready = ((count + FifoCw'(push_n)) <= FifoCw'(FifoDepth - 2));
        accept     = i_in.valid && i_in.ready;
    end

    vfhp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_in.data),
        .o_push  (push)
    );

    vfhp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_head  (o_out.data),
        .o_valid (o_out.valid),
        .o_count (count)
    );

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (count <= FifoCw'(FifoDepth - 2)))
        else $error("byte accepted without queue room");

endmodule
`default_nettype wire

// File: test/voip_frame_header_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voip_frame_header_parser_top_test
// Drives packet bytes into the frame header parser and checks every record
// it returns against a cycle-free software parser kept in step with the
// accepted bytes. Directed tests cover frame kinds, the element walk and
// length corner cases; a random stream covers the rest under back-pressure.
// ----------------------------------------------------------------------------
module voip_frame_header_parser_top_test;
    import vfhp_pkg::*;

    // Header sizes of mini and meta video frames.
    localparam int MiniHdr     = 4;
    localparam int MetaHdr     = 6;
    localparam int RandomBytes = 160;
    localparam int SteadyBytes = 80;
    localparam int MaxReports  = 10;
    localparam int DrainCycles = 16;
    localparam int HoldCycles  = 300;
    // The whole run is about 750 items; the limit leaves ample room for two
    // records per item, the 19% idling on both sides and the long output
    // hold-off in a correct run.
    localparam int CycleLimit  = 40000;

    typedef enum logic [1:0] {WalkHeader, WalkType, WalkLen, WalkData} t_walk;

    logic i_clk;
    logic i_rst_n;

    vfhp_in_if  in_ch ();
    vfhp_out_if out_ch ();

    voip_frame_header_parser_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Software copy of the parse state.
    int unsigned pr_index;
    logic [7:0]  pr_hdr [HdrBytes];
    t_walk       pr_walk;
    logic [7:0]  pr_left;
    logic [7:0]  pr_elem_type;
    logic [2:0]  pr_err;

    // Records owed by the block, oldest at owed_rd.
    t_out_item   owed_records [int unsigned];
    int unsigned owed_wr;
    int unsigned owed_rd;
    logic [7:0]  pkt[$];

    int unsigned bytes_sent;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned hold_req;
    int unsigned hold_ack;
    int          rx_hold_left;
    logic        steady;
    t_out_item   want_rec;
    t_out_item   got_rec;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Software parser
    // ------------------------------------------------------------------------
    function automatic void clear_parser();
        pr_index = 0;
        foreach (pr_hdr[k]) pr_hdr[k] = 8'd0;
        pr_walk      = WalkHeader;
        pr_left      = 8'd0;
        pr_elem_type = 8'd0;
        pr_err       = StOk;
    endfunction

    function automatic void owe_record(input t_out_item r);
        owed_records[owed_wr] = r;
        owed_wr++;
    endfunction

    // Build the summary that closes a packet of eff_len bytes.
    function automatic t_out_item frame_summary(input int unsigned eff_len);
        t_out_item r;
        r = '0;
        r.record_kind = RecSummary;
        if (pr_hdr[0][7]) begin
            // Short full frames report nothing but the status.
            if (eff_len < HdrBytes) begin
                r.status = StShortFull;
            end else begin
                r.status        = pr_err;
                r.frame_shell   = ShellFull;
                r.source_call   = {pr_hdr[0][6:0], pr_hdr[1]};
                r.dest_word     = {pr_hdr[2], pr_hdr[3]};
                r.time_stamp    = {pr_hdr[4], pr_hdr[5], pr_hdr[6], pr_hdr[7]};
                r.out_seq       = pr_hdr[8];
                r.in_seq        = pr_hdr[9];
                r.item_code     = pr_hdr[10];
                r.subclass_byte = pr_hdr[11];
                r.item_length   = LenW'(eff_len - HdrBytes);
            end
        end else if ({pr_hdr[0], pr_hdr[1]} != 16'd0) begin
            r.frame_shell = ShellMini;
            if (eff_len < MiniHdr) begin
                r.status = StShortMini;
            end else begin
                r.source_call = {pr_hdr[0][6:0], pr_hdr[1]};
                r.time_stamp  = {16'd0, pr_hdr[2], pr_hdr[3]};
                r.item_length = LenW'(eff_len - MiniHdr);
            end
        end else begin
            r.frame_shell = ShellMeta;
            // Only video meta frames are known; a missing byte 2 reads as zero.
            if (!pr_hdr[2][7]) begin
                r.status = StUnkMeta;
            end else if (eff_len <= MetaHdr) begin
                r.status = StShortMeta;
            end else begin
                r.source_call = {pr_hdr[2][6:0], pr_hdr[3]};
                r.time_stamp  = {16'd0, pr_hdr[4], pr_hdr[5]};
                r.item_length = LenW'(eff_len - MetaHdr);
            end
        end
        return r;
    endfunction

    // Advance the software parser by one accepted byte and queue its records.
    function automatic void track_byte(input logic [7:0] b, input logic [LenW-1:0] len);
        int unsigned eff;
        int unsigned pos;
        int unsigned room;
        logic        last;
        t_out_item   d;
        eff = (32'(len) > MaxPacket) ? MaxPacket : 32'(len);
        if (eff == 0) eff = 1;
        pos  = pr_index;
        // The length may change inside a packet: the current one decides.
        last = (pos + 1 >= eff);
        if (pos < HdrBytes) pr_hdr[pos] = b;
        if (pos == HdrBytes - 1) begin
            if (pr_hdr[0][7] && pr_hdr[10] == TypeIax) pr_walk = WalkType;
        end else if (pos >= HdrBytes && pr_err == StOk) begin
            case (pr_walk)
                WalkType: begin
                    pr_elem_type = b;
                    // An element cannot start on the final byte.
                    if (last) begin
                        pr_err  = StStray;
                        pr_walk = WalkHeader;
                    end else begin
                        pr_walk = WalkLen;
                    end
                end
                WalkLen: begin
                    room = last ? 0 : eff - (pos + 1);
                    if (32'(b) > room) begin
                        pr_err  = StOverrun;
                        pr_walk = WalkHeader;
                    end else begin
                        d             = '0;
                        d.record_kind = RecElement;
                        d.frame_shell = ShellFull;
                        d.item_code   = pr_elem_type;
                        d.item_length = LenW'(b);
                        d.item_offset = OffW'(pos + 1);
                        owe_record(d);
                        if (b == 8'd0) begin
                            pr_walk = WalkType;
                        end else begin
                            pr_left = b;
                            pr_walk = WalkData;
                        end
                    end
                end
                WalkData: begin
                    pr_left = pr_left - 8'd1;
                    if (pr_left == 8'd0) pr_walk = WalkType;
                end
                default: ;
            endcase
        end
        // The summary always comes after the descriptor of the same byte.
        if (last) begin
            owe_record(frame_summary(eff));
            clear_parser();
        end else begin
            pr_index = pos + 1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endfunction

    // Offer one item, idling at random first unless steady, and hold it until accepted.
    // Valid stays high afterwards so back-to-back items need no second write.
    task automatic send_byte(input logic [7:0] b, input logic [LenW-1:0] len);
        if (!steady) begin
            while ($urandom_range(0, 99) < 19) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {b, len};
        do @(posedge i_clk); while (!in_ch.ready);
        track_byte(b, len);
        bytes_sent++;
    endtask

    // Send the bytes in pkt as one packet; end any packet left open first.
    task automatic send_packet();
        if (pr_index != 0) send_byte(rnd_byte(), '0);
        foreach (pkt[k]) send_byte(pkt[k], LenW'(pkt.size()));
    endtask

    // Start pkt with a random full frame header of the given frame type.
    task automatic begin_full(input logic [7:0] ftype);
        pkt.delete();
        add_byte({1'b1, 7'($urandom_range(0, 127))});
        repeat (9) add_byte(rnd_byte());
        add_byte(ftype);
        add_byte(rnd_byte());
    endtask

    task automatic add_ie(input logic [7:0] code, input int n);
        add_byte(code);
        add_byte(8'(n));
        repeat (n) add_byte(rnd_byte());
    endtask

    task automatic trim_to(input int n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Full, mini and meta headers with extreme field values and short forms.
    task automatic test_frame_kinds();
        pkt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, TypeIax, 8'hFF};
        send_packet();
        // A full frame of another type: trailing bytes are ignored.
        pkt = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h02, 8'hFF};
        send_packet();
        begin_full(TypeIax);
        trim_to(HdrBytes - 1);
        send_packet();
        pkt = '{8'h7F, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        pkt = '{8'h00, 8'h01, 8'hAB};
        send_packet();
        pkt = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h80, 8'h01, 8'h02, 8'h03};
        send_packet();
        pkt = '{8'h00, 8'h00};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h7F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_packet();
    endtask

    // Element walk: empty and maximal elements, overrun and stray bytes.
    task automatic test_element_walk();
        begin_full(TypeIax);
        add_ie(rnd_byte(), 0);
        add_ie(rnd_byte(), 1);
        add_ie(8'hFF, 255);
        add_ie(8'h00, 3);
        send_packet();
        // Single byte after the header.
        begin_full(TypeIax);
        add_byte(rnd_byte());
        send_packet();
        begin_full(TypeIax);
        add_ie(8'h05, 2);
        add_byte(rnd_byte());
        send_packet();
        // Element longer than the bytes left.
        begin_full(TypeIax);
        add_ie(8'h07, 4);
        trim_to(pkt.size() - 2);
        send_packet();
        // Overrun early, then bytes that must be ignored.
        begin_full(TypeIax);
        add_byte(8'h09);
        add_byte(8'hFF);
        repeat (10) add_byte(rnd_byte());
        send_packet();
        // Length byte last: nonzero overruns, zero is a valid empty element.
        begin_full(TypeIax);
        add_byte(8'h0A);
        add_byte(8'h01);
        send_packet();
        begin_full(TypeIax);
        add_byte(8'h0B);
        add_byte(8'h00);
        send_packet();
    endtask

    // Zero and oversized lengths, and a length that changes mid-packet.
    task automatic test_length_edges();
        int i;
        if (pr_index != 0) send_byte(rnd_byte(), '0);
        // A length of zero makes every byte a packet of its own.
        send_byte(8'h80, '0);
        send_byte(8'h00, '0);
        send_byte(8'hFF, '0);
        send_byte(8'h01, '0);
        for (i = 0; i < 20; i++) begin
            send_byte((i == 0) ? 8'h80 : ((i == 10) ? TypeIax : rnd_byte()),
                      (i < 5) ? LenW'(8191) : LenW'(20));
        end
        // Shrink the length below the current index: the packet ends at once.
        for (i = 0; i < 9; i++) begin
            send_byte((i == 0) ? 8'h80 : rnd_byte(), (i < 8) ? LenW'(30) : LenW'(3));
        end
    endtask

    // Hold the output off for a long stretch while dense descriptor traffic
    // keeps coming, so the record queue fills and the input stalls.
    task automatic test_output_stall();
        hold_req++;
        repeat (3) begin
            begin_full(TypeIax);
            repeat (12) add_ie(rnd_byte(), 0);
            send_packet();
        end
    endtask

    // One random packet: mostly well-formed element lists, then other frame
    // kinds, truncated frames and raw noise under arbitrary lengths.
    task automatic random_packet();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick >= 95) begin
            repeat ($urandom_range(1, 20))
                send_byte(rnd_byte(), LenW'($urandom_range(0, 8191)));
            return;
        end
        if (pick < 60) begin
            begin_full(TypeIax);
            repeat ($urandom_range(0, 5))
                add_ie(rnd_byte(), ($urandom_range(0, 19) == 0) ?
                       $urandom_range(0, 255) : $urandom_range(0, 6));
            case ($urandom_range(0, 9))
                0: add_byte(rnd_byte());
                1: begin
                    add_byte(rnd_byte());
                    add_byte(8'($urandom_range(1, 40)));
                end
                2: if (pkt.size() > HdrBytes + 1) trim_to(pkt.size() - $urandom_range(1, 3));
                default: ;
            endcase
        end else if (pick < 68) begin
            begin_full(rnd_byte());
            repeat ($urandom_range(0, 10)) add_byte(rnd_byte());
        end else if (pick < 78) begin
            pkt.delete();
            add_byte(8'($urandom_range(0, 127)));
            add_byte(rnd_byte());
            if (pkt[0] == 8'd0 && pkt[1] == 8'd0) pkt[1] = 8'd1;
            repeat (12) add_byte(rnd_byte());
            trim_to($urandom_range(1, 14));
        end else if (pick < 88) begin
            pkt = '{8'h00, 8'h00};
            add_byte({($urandom_range(0, 3) != 0), 7'($urandom_range(0, 127))});
            repeat (11) add_byte(rnd_byte());
            trim_to($urandom_range(1, 14));
        end else begin
            begin_full(rnd_byte());
            trim_to($urandom_range(1, HdrBytes - 1));
        end
        send_packet();
    endtask

    task automatic test_random_stream();
        int unsigned start;
        start  = bytes_sent;
        // Open with a stretch where neither side idles.
        steady = 1'b1;
        while (bytes_sent - start < RandomBytes) begin
            if (steady && bytes_sent - start >= SteadyBytes) steady = 1'b0;
            random_packet();
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    // Drop ready at random, or for the whole of a requested hold-off.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack     = hold_req;
            rx_hold_left = HoldCycles;
        end
        if (rx_hold_left > 0) begin
            out_ch.ready <= 1'b0;
            rx_hold_left--;
        end else begin
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    function automatic string show_record(input t_out_item r);
        return $sformatf({"kind=%0d st=%0d shell=%0d src=%h dst=%h ts=%h oseq=%h iseq=%h",
                          " code=%h sub=%h len=%0d off=%0d"},
                         r.record_kind, r.status, r.frame_shell, r.source_call,
                         r.dest_word, r.time_stamp, r.out_seq, r.in_seq, r.item_code,
                         r.subclass_byte, r.item_length, r.item_offset);
    endfunction

    function automatic string diff_fields(input t_out_item w, input t_out_item g);
        string s;
        s = "";
        if (w.record_kind   !== g.record_kind)   s = {s, " record_kind"};
        if (w.status        !== g.status)        s = {s, " status"};
        if (w.frame_shell   !== g.frame_shell)   s = {s, " frame_shell"};
        if (w.source_call   !== g.source_call)   s = {s, " source_call"};
        if (w.dest_word     !== g.dest_word)     s = {s, " dest_word"};
        if (w.time_stamp    !== g.time_stamp)    s = {s, " time_stamp"};
        if (w.out_seq       !== g.out_seq)       s = {s, " out_seq"};
        if (w.in_seq        !== g.in_seq)        s = {s, " in_seq"};
        if (w.item_code     !== g.item_code)     s = {s, " item_code"};
        if (w.subclass_byte !== g.subclass_byte) s = {s, " subclass_byte"};
        if (w.item_length   !== g.item_length)   s = {s, " item_length"};
        if (w.item_offset   !== g.item_offset)   s = {s, " item_offset"};
        return s;
    endfunction

    task automatic report_failure(input string what, input t_out_item want,
                                  input t_out_item got);
        fail_count++;
        if (fail_count <= MaxReports) begin
            $display("%0t: %s", $time, what);
            $display("  expected %s", show_record(want));
            $display("  actual   %s", show_record(got));
        end
    endtask

    // Check every accepted record against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_rec = out_ch.data;
            if (owed_rd == owed_wr) begin
                report_failure("record with nothing pending", '0, got_rec);
            end else begin
                want_rec = owed_records[owed_rd];
                owed_rd++;
                if (got_rec !== want_rec)
                    report_failure({"mismatch in", diff_fields(want_rec, got_rec)},
                                   want_rec, got_rec);
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        steady       = 1'b0;
        hold_req     = 0;
        bytes_sent   = 0;
        owed_wr      = 0;
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_kinds();
        test_element_walk();
        test_length_edges();
        test_output_stall();
        test_random_stream();
        in_ch.valid <= 1'b0;

        // Drain what is owed, then watch a little longer for extra records.
        while (owed_rd != owed_wr) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
